// ===== rtl/adaptive_corner_threshold_regulator_macros.svh =====
// Assertion macros shared by the corner threshold regulator RTL.
`ifndef ADAPTIVE_CORNER_THRESHOLD_REGULATOR_MACROS_SVH
`define ADAPTIVE_CORNER_THRESHOLD_REGULATOR_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off during reset.
`define ACTR_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off during reset.
`define ACTR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/actr_pkg.sv =====
// Types and constants of the corner threshold regulator.
package actr_pkg;

  localparam int unsigned CellW   = 6;
  localparam int unsigned CountW  = 12;
  localparam int unsigned BandW   = 13;
  localparam int unsigned ThrW    = 8;
  localparam int unsigned HistW   = 9;
  localparam int unsigned TrialW  = 4;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgW    = 13;
  localparam int unsigned InDataW = 24;
  localparam int unsigned InUserW = 2;
  localparam int unsigned OutDataW = 8;

  localparam logic [HistW-1:0]  HistLastRst  = 9'h1FF;
  localparam logic [HistW-1:0]  HistOlderRst = 9'h1FE;
  localparam logic [TrialW-1:0] TrialMax     = 4'hF;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_LOW_INNER  = 3'd0,
    CFG_LOW_OUTER  = 3'd1,
    CFG_HIGH_INNER = 3'd2,
    CFG_HIGH_OUTER = 3'd3,
    CFG_FLOOR      = 3'd4,
    CFG_CEILING    = 3'd5,
    CFG_START      = 3'd6,
    CFG_TRIALS     = 3'd7
  } cfg_reg_e;

  typedef struct packed {
    logic [BandW-1:0]  low_inner;
    logic [BandW-1:0]  low_outer;
    logic [BandW-1:0]  high_inner;
    logic [BandW-1:0]  high_outer;
    logic [ThrW-1:0]   floor_thr;
    logic [ThrW-1:0]   ceiling_thr;
    logic [ThrW-1:0]   start_thr;
    logic [TrialW-1:0] trial_limit;
  } cfg_t;

endpackage

// ===== rtl/actr_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module actr_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/adaptive_corner_threshold_regulator.sv =====
// Top level of the adaptive corner threshold regulator.
// Usage: each slave beat carries one detection trial of one grid cell
// (cell number and corner count in tdata, row and cell begin flags in
// tuser). Each accepted beat yields exactly one master beat with the
// updated cell threshold in tdata and the retry request in tuser.
// Throughput: one beat per cycle while the receiver is ready, set by
// the per-cell threshold table RAM (registered read) with a one-entry
// bypass of the latest write; the read stage feeds a result register.
// Registers are written through the cfg channel (index, data), always
// ready; write them only while the block is idle. Writing the start
// threshold reloads every cell by clearing the per-cell valid bits.
// Reset restores the register defaults, marks every cell as holding the
// start threshold, and resets the row history and trial counter.
// A stalled receiver holds the result register; one further beat is
// taken into the read stage, then tready drops until the result moves.
// Cells at or beyond NUM_CELLS return threshold 0, no retry, no update.
`include "adaptive_corner_threshold_regulator_macros.svh"

module adaptive_corner_threshold_regulator
  import actr_pkg::*;
#(
  parameter int unsigned NUM_CELLS = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // [5:0] cell_number, [17:6] corner_count, [23:18] zero
  input  logic [InDataW-1:0]  s_axis_tdata,
  // [0] row_begin, [1] cell_begin
  input  logic [InUserW-1:0]  s_axis_tuser,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // [7:0] new_threshold
  output logic [OutDataW-1:0] m_axis_tdata,
  // [0] retry
  output logic [0:0]          m_axis_tuser,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgW-1:0]     cfg_data_i
);

  localparam int unsigned AddrW = (NUM_CELLS > 1) ? $clog2(NUM_CELLS) : 1;

  cfg_t              cfg_q;
  logic              in_accept;
  logic              advance;

  logic              s1_valid_q;
  logic              s1_row_begin_q;
  logic              s1_cell_begin_q;
  logic [CellW-1:0]  s1_cell_q;
  logic [CountW-1:0] s1_count_q;
  logic [AddrW-1:0]  s1_addr;
  logic              in_range;

  logic [NUM_CELLS-1:0] vld_q;
  logic              byp_valid_q;
  logic [AddrW-1:0]  byp_addr_q;
  logic [ThrW-1:0]   byp_thr_q;
  logic [ThrW-1:0]   ram_rdata;

  logic [HistW-1:0]  last_q;
  logic [HistW-1:0]  older_q;
  logic [TrialW-1:0] trial_q;

  logic              out_valid_q;
  logic [ThrW-1:0]   out_thr_q;
  logic              out_retry_q;

  logic [ThrW-1:0]   thr_cur;
  logic [ThrW-1:0]   thr_d;
  logic [HistW-1:0]  last_eff;
  logic [HistW-1:0]  older_eff;
  logic [TrialW-1:0] trial_eff;
  logic [HistW-1:0]  last_d;
  logic [HistW-1:0]  older_d;
  logic [TrialW-1:0] trial_d;
  logic              osc;
  logic              two_step;
  logic              retry_d;
  logic [BandW-1:0]  count_ext;
  logic [ThrW-1:0]   thr_m1;
  logic [ThrW-1:0]   thr_p1;
  logic [TrialW:0]   trial_next;

  assign cfg_ready_o   = 1'b1;
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign advance       = s1_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !s1_valid_q || advance;

  assign s1_addr  = AddrW'(s1_cell_q);
  assign in_range = 32'(s1_cell_q) < NUM_CELLS;

  actr_ram #(
    .Width (ThrW),
    .Depth (NUM_CELLS)
  ) u_thr_ram (
    .clk_i   (clk_i),
    .we_i    (advance && in_range),
    .waddr_i (s1_addr),
    .wdata_i (thr_d),
    .re_i    (in_accept),
    .raddr_i (AddrW'(s_axis_tdata[CellW-1:0])),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    if (byp_valid_q && byp_addr_q == s1_addr) begin
      thr_cur = byp_thr_q;
    end else if (vld_q[s1_addr]) begin
      thr_cur = ram_rdata;
    end else begin
      thr_cur = cfg_q.start_thr;
    end

    last_eff  = s1_row_begin_q ? HistLastRst : last_q;
    older_eff = s1_row_begin_q ? HistOlderRst : older_q;
    trial_eff = s1_cell_begin_q ? '0 : trial_q;
    count_ext = BandW'(s1_count_q);
    thr_m1    = thr_cur - 8'd1;
    thr_p1    = thr_cur + 8'd1;

    osc      = {1'b0, thr_cur} == older_eff;
    thr_d    = thr_cur;
    two_step = 1'b0;
    last_d   = last_eff;
    older_d  = older_eff;
    if (!osc) begin
      older_d = last_eff;
      last_d  = {1'b0, thr_cur};
      if (count_ext < cfg_q.low_inner) begin
        if (thr_cur > cfg_q.floor_thr) begin
          thr_d = thr_m1;
          if (count_ext < cfg_q.low_outer && thr_m1 > cfg_q.floor_thr) begin
            thr_d    = thr_cur - 8'd2;
            two_step = 1'b1;
          end
        end
      end else if (count_ext > cfg_q.high_inner) begin
        if (thr_cur < cfg_q.ceiling_thr) begin
          thr_d = thr_p1;
          if (count_ext > cfg_q.high_outer && thr_p1 < cfg_q.ceiling_thr) begin
            thr_d    = thr_cur + 8'd2;
            two_step = 1'b1;
          end
        end
      end
    end

    trial_next = {1'b0, trial_eff} + 5'd1;
    retry_d    = two_step && (trial_next < {1'b0, cfg_q.trial_limit});
    trial_d    = (trial_eff < TrialMax) ? trial_next[TrialW-1:0] : trial_eff;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.low_inner   <= 13'd10;
      cfg_q.low_outer   <= 13'd7;
      cfg_q.high_inner  <= 13'd10;
      cfg_q.high_outer  <= 13'd13;
      cfg_q.floor_thr   <= 8'd5;
      cfg_q.ceiling_thr <= 8'd80;
      cfg_q.start_thr   <= 8'd20;
      cfg_q.trial_limit <= 4'd3;
      s1_valid_q        <= 1'b0;
      out_valid_q       <= 1'b0;
      vld_q             <= '0;
      byp_valid_q       <= 1'b0;
      last_q            <= HistLastRst;
      older_q           <= HistOlderRst;
      trial_q           <= '0;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_reg_e'(cfg_index_i))
          CFG_LOW_INNER:  cfg_q.low_inner   <= cfg_data_i;
          CFG_LOW_OUTER:  cfg_q.low_outer   <= cfg_data_i;
          CFG_HIGH_INNER: cfg_q.high_inner  <= cfg_data_i;
          CFG_HIGH_OUTER: cfg_q.high_outer  <= cfg_data_i;
          CFG_FLOOR:      cfg_q.floor_thr   <= cfg_data_i[ThrW-1:0];
          CFG_CEILING:    cfg_q.ceiling_thr <= cfg_data_i[ThrW-1:0];
          CFG_START: begin
            cfg_q.start_thr <= cfg_data_i[ThrW-1:0];
            vld_q           <= '0;
            byp_valid_q     <= 1'b0;
          end
          CFG_TRIALS:     cfg_q.trial_limit <= cfg_data_i[TrialW-1:0];
          default: ;
        endcase
      end
      if (in_accept) begin
        s1_valid_q <= 1'b1;
      end else if (advance) begin
        s1_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      if (advance && in_range) begin
        vld_q[s1_addr] <= 1'b1;
        byp_valid_q    <= 1'b1;
        last_q         <= last_d;
        older_q        <= older_d;
        trial_q        <= trial_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_row_begin_q  <= s_axis_tuser[0];
      s1_cell_begin_q <= s_axis_tuser[1];
      s1_cell_q       <= s_axis_tdata[CellW-1:0];
      s1_count_q      <= s_axis_tdata[CellW+CountW-1:CellW];
    end
    if (advance) begin
      out_thr_q   <= in_range ? thr_d : '0;
      out_retry_q <= in_range && retry_d;
    end
    if (advance && in_range) begin
      byp_addr_q <= s1_addr;
      byp_thr_q  <= thr_d;
    end
  end

  assign m_axis_tvalid   = out_valid_q;
  assign m_axis_tdata    = out_thr_q;
  assign m_axis_tuser[0] = out_retry_q;

  `ACTR_ASSERT_SAME(a_ready_drop, !s_axis_tready, s1_valid_q && out_valid_q && !m_axis_tready, "tready low without a full pipeline")
  `ACTR_ASSERT_NEXT(a_out_of_range, advance && !in_range, m_axis_tdata == '0 && m_axis_tuser == '0, "out-of-range cell gave a nonzero result")
  `ACTR_ASSERT_SAME(a_retry_moves, advance && retry_d, thr_d != thr_cur && !osc, "retry without a threshold move")
  `ACTR_ASSERT_NEXT(a_trial_sat, advance && in_range && !s1_cell_begin_q && trial_q == TrialMax, trial_q == TrialMax, "trial counter left saturation")

endmodule

// ===== tb/sv/tb_adaptive_corner_threshold_regulator.sv =====
// Self-checking stream testbench for the adaptive corner threshold regulator.
module tb_adaptive_corner_threshold_regulator;
  timeunit 1ns;
  timeprecision 1ps;
  import actr_pkg::*;

  localparam int NumCells = 64;

  typedef struct packed {
    logic [ThrW-1:0] thr;
    logic            retry;
  } cell_update_t;

  logic                clk_i;
  logic                rst_ni;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata;
  logic [InUserW-1:0]  s_axis_tuser;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [OutDataW-1:0] m_axis_tdata;
  logic [0:0]          m_axis_tuser;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [CfgW-1:0]     cfg_data_i;

  adaptive_corner_threshold_regulator #(
    .NUM_CELLS(NumCells)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  cfg_t             regs_now;
  logic [ThrW-1:0]  thr_by_cell [NumCells];
  int               hist_last;
  int               hist_older;
  logic [TrialW-1:0] trials_done;
  cell_update_t     pending_updates [$];

  int err_count = 0;
  int trials_sent = 0;
  int results_seen = 0;
  int retries_seen = 0;
  int holds_seen = 0;
  int setting_count = 0;
  bit idling_on = 1'b1;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #2ms;
    $display("%0t timeout", $time);
    $display("DONE: errors detected");
    $finish;
  end

  function automatic void reload_cells();
    for (int k = 0; k < NumCells; k++) thr_by_cell[k] = regs_now.start_thr;
  endfunction

  function automatic cell_update_t predict_update(input logic row_b, input logic cell_b,
                                                  input logic [CellW-1:0] cell_no,
                                                  input logic [CountW-1:0] cnt);
    cell_update_t r;
    int thr;
    logic two_step;
    r = '0;
    two_step = 1'b0;
    if (cell_no >= NumCells) return r;
    if (row_b) begin
      hist_last = -1;
      hist_older = -2;
    end
    if (cell_b) trials_done = '0;
    thr = int'(thr_by_cell[cell_no]);
    if (thr != hist_older) begin
      hist_older = hist_last;
      hist_last = thr;
      if (cnt < regs_now.low_inner) begin
        if (thr > regs_now.floor_thr) begin
          thr--;
          if (cnt < regs_now.low_outer && thr > regs_now.floor_thr) begin
            thr--;
            two_step = 1'b1;
          end
        end
      end else if (cnt > regs_now.high_inner) begin
        if (thr < regs_now.ceiling_thr) begin
          thr++;
          if (cnt > regs_now.high_outer && thr < regs_now.ceiling_thr) begin
            thr++;
            two_step = 1'b1;
          end
        end
      end
    end else begin
      holds_seen++;
    end
    r.retry = two_step && (int'(trials_done) + 1 < int'(regs_now.trial_limit));
    if (trials_done != TrialMax) trials_done++;
    thr_by_cell[cell_no] = thr[ThrW-1:0];
    r.thr = thr[ThrW-1:0];
    if (r.retry) retries_seen++;
    return r;
  endfunction

  task automatic send_trial(input logic row_b, input logic cell_b,
                            input logic [CellW-1:0] cell_no, input logic [CountW-1:0] cnt,
                            output logic retry_req);
    cell_update_t r;
    @(negedge clk_i);
    if (idling_on && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(InDataW-CellW-CountW){1'b0}}, cnt, cell_no};
    s_axis_tuser  <= {cell_b, row_b};
    do @(posedge clk_i); while (!s_axis_tready);
    r = predict_update(row_b, cell_b, cell_no, cnt);
    pending_updates.insert(pending_updates.size(), r);
    trials_sent++;
    retry_req = r.retry;
  endtask

  task automatic stream_idle();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
  endtask

  task automatic wait_drained();
    int guard;
    guard = 0;
    while (pending_updates.size() != 0 && guard < 4000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [CfgW-1:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_LOW_INNER:  regs_now.low_inner   = val[BandW-1:0];
      CFG_LOW_OUTER:  regs_now.low_outer   = val[BandW-1:0];
      CFG_HIGH_INNER: regs_now.high_inner  = val[BandW-1:0];
      CFG_HIGH_OUTER: regs_now.high_outer  = val[BandW-1:0];
      CFG_FLOOR:      regs_now.floor_thr   = val[ThrW-1:0];
      CFG_CEILING:    regs_now.ceiling_thr = val[ThrW-1:0];
      CFG_START: begin
        regs_now.start_thr = val[ThrW-1:0];
        reload_cells();
      end
      CFG_TRIALS:     regs_now.trial_limit = val[TrialW-1:0];
      default: ;
    endcase
  endtask

  task automatic apply_settings(input cfg_t s, input bit reload);
    stream_idle();
    wait_drained();
    write_reg(CFG_LOW_INNER, CfgW'(s.low_inner));
    write_reg(CFG_LOW_OUTER, CfgW'(s.low_outer));
    write_reg(CFG_HIGH_INNER, CfgW'(s.high_inner));
    write_reg(CFG_HIGH_OUTER, CfgW'(s.high_outer));
    write_reg(CFG_FLOOR, CfgW'(s.floor_thr));
    write_reg(CFG_CEILING, CfgW'(s.ceiling_thr));
    write_reg(CFG_TRIALS, CfgW'(s.trial_limit));
    if (reload) write_reg(CFG_START, CfgW'(s.start_thr));
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    setting_count++;
  endtask

  function automatic cfg_t make_settings(input int li, input int lo, input int hi, input int ho,
                                         input int fl, input int ce, input int st,
                                         input int tl);
    cfg_t s;
    s.low_inner   = BandW'(li);
    s.low_outer   = BandW'(lo);
    s.high_inner  = BandW'(hi);
    s.high_outer  = BandW'(ho);
    s.floor_thr   = ThrW'(fl);
    s.ceiling_thr = ThrW'(ce);
    s.start_thr   = ThrW'(st);
    s.trial_limit = TrialW'(tl);
    return s;
  endfunction

  function automatic logic [CountW-1:0] pick_count();
    int base;
    int v;
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2, 3: begin
        case ($urandom_range(0, 3))
          0: base = int'(regs_now.low_inner);
          1: base = int'(regs_now.low_outer);
          2: base = int'(regs_now.high_inner);
          default: base = int'(regs_now.high_outer);
        endcase
        v = base + int'($urandom_range(0, 6)) - 3;
        if (v < 0) v = 0;
        if (v > 4095) v = 4095;
        return v[CountW-1:0];
      end
      default: return CountW'($urandom_range(0, 4095));
    endcase
  endfunction

  task automatic run_rows(input int n_items);
    int sent;
    int n_cells;
    logic [CellW-1:0] cell_no;
    logic rq;
    sent = 0;
    while (sent < n_items) begin
      n_cells = $urandom_range(1, 8);
      cell_no = CellW'($urandom_range(0, NumCells - 1));
      for (int c = 0; c < n_cells && sent < n_items; c++) begin
        case ($urandom_range(0, 19))
          0, 1: begin
            send_trial(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                       CellW'($urandom_range(0, NumCells - 1)),
                       CountW'($urandom_range(0, 4095)), rq);
            sent++;
          end
          2: begin
            for (int k = 0; k < 18; k++) begin
              send_trial(c == 0 && k == 0, k == 0, cell_no, pick_count(), rq);
              sent++;
            end
          end
          default: begin
            send_trial(c == 0, 1'b1, cell_no, pick_count(), rq);
            sent++;
            while (rq && $urandom_range(0, 9) != 0) begin
              send_trial(1'b0, 1'b0, cell_no, pick_count(), rq);
              sent++;
            end
          end
        endcase
        if ($urandom_range(0, 3) == 0) cell_no = CellW'($urandom_range(0, NumCells - 1));
        else cell_no = cell_no + 1'b1;
      end
    end
  endtask

  task automatic test_directed();
    logic rq;
    send_trial(1'b1, 1'b1, 6'd0, 12'd0, rq);
    send_trial(1'b0, 1'b0, 6'd0, 12'd4095, rq);
    send_trial(1'b0, 1'b0, 6'd0, 12'd4095, rq);
    send_trial(1'b0, 1'b0, 6'd0, 12'd4095, rq);
    send_trial(1'b1, 1'b1, 6'd63, 12'd6, rq);
    send_trial(1'b0, 1'b0, 6'd63, 12'd7, rq);
    send_trial(1'b0, 1'b0, 6'd63, 12'd9, rq);
    send_trial(1'b0, 1'b0, 6'd63, 12'd10, rq);
    send_trial(1'b0, 1'b0, 6'd63, 12'd11, rq);
    send_trial(1'b0, 1'b0, 6'd63, 12'd13, rq);
    send_trial(1'b0, 1'b1, 6'd63, 12'd14, rq);
    for (int k = 0; k < 9; k++) send_trial(1'b1, 1'b0, 6'd1, 12'd0, rq);
    send_trial(1'b1, 1'b1, 6'd2, 12'd13, rq);
    send_trial(1'b0, 1'b1, 6'd42, 12'd2730, rq);
    send_trial(1'b1, 1'b0, 6'd21, 12'd1365, rq);
  endtask

  task automatic test_extreme_settings();
    apply_settings(make_settings(0, 0, 0, 0, 0, 255, 0, 15), 1'b1);
    run_rows(70);
    apply_settings(make_settings(4096, 4096, 4096, 4096, 0, 255, 255, 1), 1'b1);
    run_rows(70);
    apply_settings(make_settings(10, 7, 10, 13, 255, 0, 128, 0), 1'b1);
    run_rows(60);
    apply_settings(make_settings(3000, 4096, 1000, 0, 40, 200, 120, 7), 1'b1);
    run_rows(70);
    apply_settings(make_settings(10, 7, 10, 13, 5, 80, 20, 15), 1'b0);
    run_rows(70);
  endtask

  task automatic test_random_settings();
    cfg_t s;
    for (int p = 0; p < 5; p++) begin
      s.low_inner   = BandW'($urandom_range(0, 40));
      s.low_outer   = BandW'($urandom_range(0, 40));
      s.high_inner  = BandW'($urandom_range(0, 40));
      s.high_outer  = BandW'($urandom_range(0, 60));
      if ($urandom_range(0, 3) == 0) s.high_outer = BandW'($urandom_range(0, 4096));
      s.floor_thr   = ThrW'($urandom_range(0, 60));
      s.ceiling_thr = ThrW'($urandom_range(100, 255));
      s.start_thr   = ThrW'($urandom_range(0, 255));
      s.trial_limit = TrialW'($urandom_range(0, 15));
      apply_settings(s, 1'($urandom_range(0, 1)));
      run_rows(150);
    end
  endtask

  task automatic test_steady_tail();
    apply_settings(make_settings(12, 6, 14, 20, 3, 250, 50, 4), 1'b1);
    idling_on = 1'b0;
    run_rows(230);
  endtask

  initial begin
    int hold;
    hold = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold > 0) begin
        hold--;
        m_axis_tready <= 1'b0;
      end else if (idling_on && $urandom_range(0, 5) == 0) begin
        hold = $urandom_range(1, 4) - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    cell_update_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      results_seen++;
      if (pending_updates.size() == 0) begin
        $display("%0t unexpected beat: expected none, actual thr %0d retry %0b",
                 $time, m_axis_tdata, m_axis_tuser);
        err_count++;
      end else begin
        want = pending_updates.pop_front();
        if (m_axis_tdata !== want.thr) begin
          $display("%0t new_threshold: expected %0d actual %0d", $time, want.thr, m_axis_tdata);
          err_count++;
        end
        if (m_axis_tuser[0] !== want.retry) begin
          $display("%0t retry: expected %0b actual %0b", $time, want.retry, m_axis_tuser[0]);
          err_count++;
        end
      end
    end
  end

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = CFG_LOW_INNER;
    cfg_data_i    = '0;
    regs_now      = make_settings(10, 7, 10, 13, 5, 80, 20, 3);
    reload_cells();
    hist_last     = -1;
    hist_older    = -2;
    trials_done   = '0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_directed();
    test_extreme_settings();
    test_random_settings();
    test_steady_tail();

    stream_idle();
    wait_drained();
    repeat (8) @(posedge clk_i);
    if (pending_updates.size() != 0) begin
      $display("%0t missing beats: expected %0d more, actual 0", $time, pending_updates.size());
      err_count += pending_updates.size();
    end
    $display("Ran %0d trials over %0d register settings; %0d result beats checked.",
             trials_sent, setting_count + 1, results_seen);
    $display("Saw %0d retry requests and %0d oscillation holds.", retries_seen, holds_seen);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
